[sv/tnil_pkg.sv]
// Shared types and constants of the top-N insertion list.
`timescale 1ns / 1ps

package tnil_pkg;

    // Built depth of the list.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths.
    localparam int COUNT_W  = 32;
    localparam int TAG_W    = 32;
    localparam int POS_W    = 4;
    localparam int LENREG_W = 5;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [LENREG_W-1:0] LIST_LENGTH_RESET = 5'd10;
    localparam logic REG_LIST_LENGTH = 1'b0;

    // Input actions.
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_OFFER = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Input beat.
    typedef struct packed {
        action_t             action;
        logic [COUNT_W-1:0]  offer_count;
        logic [TAG_W-1:0]    offer_tag;
        logic [POS_W-1:0]    read_index;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic                placed;
        logic [POS_W-1:0]    placed_position;
        logic                entry_valid;
        logic [COUNT_W-1:0]  entry_count;
        logic [TAG_W-1:0]    entry_tag;
    } out_beat_t;

    // Control handed to each cell.
    typedef struct packed {
        logic clear;
        logic offer;
        logic in_use;
        logic found_in;
    } cell_ctrl_t;

endpackage

[sv/tnil_cell.sv]
// One list position: holds an entry, compares against the offer, shifts down.
`timescale 1ns / 1ps

module tnil_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tnil_pkg::cell_ctrl_t        ctrl,
    input  logic [tnil_pkg::COUNT_W-1:0] offer_count,
    input  logic [tnil_pkg::TAG_W-1:0]   offer_tag,
    input  logic [tnil_pkg::COUNT_W-1:0] prev_count,
    input  logic [tnil_pkg::TAG_W-1:0]   prev_tag,
    input  logic                        prev_valid,
    output logic [tnil_pkg::COUNT_W-1:0] count,
    output logic [tnil_pkg::TAG_W-1:0]   tag,
    output logic                        valid,
    output logic                        found_out,
    output logic                        ins
);
    import tnil_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               valid_reg, valid_next;
    logic               gt;

    // Compare the offer against this position and pass the find down the row
    assign gt        = ctrl.in_use && (offer_count > count_reg);
    assign ins       = ctrl.offer && gt && !ctrl.found_in;
    assign found_out = ctrl.found_in || gt;

    // Clear, take the neighbour's entry, take the offer, or hold
    always_comb
    begin
        count_next = count_reg;
        tag_next   = tag_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            valid_next = 1'b0;
        end
        else if (ctrl.offer && ctrl.in_use)
        begin
            if (ctrl.found_in)
            begin
                count_next = prev_count;
                tag_next   = prev_tag;
                valid_next = prev_valid;
            end
            else if (gt)
            begin
                count_next = offer_count;
                tag_next   = offer_tag;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Tags need no reset: they are only shown behind a valid mark
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign count = count_reg;
    assign tag   = tag_reg;
    assign valid = valid_reg;

endmodule

[sv/top_n_insertion_list.sv]
// Top level of the top-N insertion list: cell row, result register, register port.
`timescale 1ns / 1ps

// Keeps the DEPTH largest counts seen since the last clear, in descending order, each
// with a 32-bit tag, in a row of DEPTH cells. The offer is compared in all cells at once,
// the first in-use cell holding a smaller count takes it and the cells below it shift
// down one place, so one beat is accepted per cycle while the result register is free or
// being taken. Each beat gives exactly one result beat, registered, in the cycle after
// acceptance. list_length (address 0) sets the positions in use; 0 acts as 1 and values
// above DEPTH act as DEPTH. Write it only while idle.
module top_n_insertion_list #(
    parameter int DEPTH = tnil_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tnil_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output tnil_pkg::out_beat_t          out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tnil_pkg::PADDR_W-1:0] paddr,
    input  logic [tnil_pkg::PDATA_W-1:0] pwdata,
    output logic [tnil_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import tnil_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int CW    = (LEN_W > LENREG_W) ? LEN_W : LENREG_W;
    localparam int IW    = $clog2(DEPTH);
    localparam int RW    = (IW > POS_W) ? IW : POS_W;

    logic [LENREG_W-1:0] list_length_reg;
    logic [CW-1:0]       len_raw;
    logic [CW-1:0]       used_len;
    logic                in_fire;
    logic                out_valid_reg;
    out_beat_t           out_reg, out_next;

    logic [COUNT_W-1:0] cell_count [DEPTH];
    logic [TAG_W-1:0]   cell_tag   [DEPTH];
    logic [DEPTH-1:0]   cell_valid;
    logic [DEPTH-1:0]   cell_found;
    logic [DEPTH-1:0]   cell_ins;
    logic [DEPTH-1:0]   in_use;
    logic [DEPTH-1:0]   rd_sel;
    cell_ctrl_t         cell_ctrl [DEPTH];

    logic [POS_W-1:0]   ins_pos;
    logic [COUNT_W-1:0] rd_count;
    logic [TAG_W-1:0]   rd_tag;
    logic               rd_valid;

    // Register port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_length_reg <= LIST_LENGTH_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_LIST_LENGTH)
        begin
            list_length_reg <= pwdata[LENREG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LIST_LENGTH) ?
                    {{(PDATA_W-LENREG_W){1'b0}}, list_length_reg} : '0;

    // Clamp the length in use to 1..DEPTH
    assign len_raw = CW'(list_length_reg);

    always_comb
    begin
        priority if (len_raw == '0)
        begin
            used_len = CW'(1);
        end
        else if (len_raw > CW'(DEPTH))
        begin
            used_len = CW'(DEPTH);
        end
        else
        begin
            used_len = len_raw;
        end
    end

    // Accept a beat whenever the result register is free or being taken
    assign in_stall  = out_valid_reg && out_stall;
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign in_use[i]             = CW'(i) < used_len;
        assign cell_ctrl[i].clear    = in_fire && (in_data.action == ACT_CLEAR);
        assign cell_ctrl[i].offer    = in_fire && (in_data.action == ACT_OFFER);
        assign cell_ctrl[i].in_use   = in_use[i];
        assign rd_sel[i] = (RW'(in_data.read_index) == RW'(i)) && in_use[i] && cell_valid[i];

        if (i == 0)
        begin : g_first
            assign cell_ctrl[i].found_in = 1'b0;
            tnil_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl[i]),
                .offer_count (in_data.offer_count),
                .offer_tag   (in_data.offer_tag),
                .prev_count  ('0),
                .prev_tag    ('0),
                .prev_valid  (1'b0),
                .count       (cell_count[i]),
                .tag         (cell_tag[i]),
                .valid       (cell_valid[i]),
                .found_out   (cell_found[i]),
                .ins         (cell_ins[i])
            );
        end
        else
        begin : g_rest
            assign cell_ctrl[i].found_in = cell_found[i-1];
            tnil_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl[i]),
                .offer_count (in_data.offer_count),
                .offer_tag   (in_data.offer_tag),
                .prev_count  (cell_count[i-1]),
                .prev_tag    (cell_tag[i-1]),
                .prev_valid  (cell_valid[i-1]),
                .count       (cell_count[i]),
                .tag         (cell_tag[i]),
                .valid       (cell_valid[i]),
                .found_out   (cell_found[i]),
                .ins         (cell_ins[i])
            );
        end
    end

    // Encode the insertion place and select the read entry
    always_comb
    begin
        ins_pos  = '0;
        rd_count = '0;
        rd_tag   = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (cell_ins[k])
            begin
                ins_pos = ins_pos | POS_W'(k);
            end
            if (rd_sel[k])
            begin
                rd_count = rd_count | cell_count[k];
                rd_tag   = rd_tag | cell_tag[k];
            end
        end
    end

    assign rd_valid = |rd_sel;

    // Build the result beat
    always_comb
    begin
        out_next = '0;
        unique case (in_data.action)
            ACT_OFFER:
            begin
                out_next.placed          = |cell_ins;
                out_next.placed_position = ins_pos;
            end
            ACT_READ:
            begin
                out_next.entry_valid = rd_valid;
                out_next.entry_count = rd_count;
                out_next.entry_tag   = rd_tag;
            end
            ACT_CLEAR, ACT_NONE:
            begin
                out_next = '0;
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= out_next;
        end
    end

    // Checks
    a_ins_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_ins))
        else $error("more than one cell took the offer");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.action == ACT_CLEAR |=> cell_valid == '0)
        else $error("valid marks left after clear");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty result register");

    a_offer_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.placed |-> !out_reg.entry_valid)
        else $error("offer result carries a read entry");

endmodule

[verif/top_n_insertion_list_tb.sv]
// Self-checking testbench of the top-N insertion list: directed and random beats.
`timescale 1ns / 1ps

module top_n_insertion_list_tb;
    import tnil_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 8;

    // Mirror of the ranking list; predicts one result beat per accepted input beat.
    class ranking_board;
        logic [COUNT_W-1:0]  counts [LIST_DEPTH];
        logic [TAG_W-1:0]    tags   [LIST_DEPTH];
        bit                  marks  [LIST_DEPTH];
        logic [LENREG_W-1:0] length_reg;
        out_beat_t           due_results [$];
        int                  mismatch_count;

        function new();
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                counts[i] = '0;
                tags[i]   = '0;
                marks[i]  = 1'b0;
            end
            length_reg     = LIST_LENGTH_RESET;
            mismatch_count = 0;
        endfunction

        function void set_length(logic [PDATA_W-1:0] word);
            length_reg = word[LENREG_W-1:0];
        endfunction

        // Clamp the register to the positions actually in use.
        function int positions_in_use();
            int n;
            n = length_reg;
            if (n < 1)
                n = 1;
            if (n > LIST_DEPTH)
                n = LIST_DEPTH;
            return n;
        endfunction

        // Work out the result of one accepted beat and advance the list.
        function void note_beat(in_beat_t beat);
            out_beat_t res;
            int        len;
            bit        found;
            res   = '0;
            len   = positions_in_use();
            found = 1'b0;
            case (beat.action)
                ACT_CLEAR:
                begin
                    // Tags stay as they are.
                    for (int i = 0; i < LIST_DEPTH; i++)
                    begin
                        counts[i] = '0;
                        marks[i]  = 1'b0;
                    end
                end
                ACT_OFFER:
                begin
                    // First strictly smaller count takes the offer; ties go below.
                    for (int i = 0; i < len; i++)
                    begin
                        if (!found && beat.offer_count > counts[i])
                        begin
                            for (int j = len - 1; j > i; j--)
                            begin
                                counts[j] = counts[j-1];
                                tags[j]   = tags[j-1];
                                marks[j]  = marks[j-1];
                            end
                            counts[i]           = beat.offer_count;
                            tags[i]             = beat.offer_tag;
                            marks[i]            = 1'b1;
                            found               = 1'b1;
                            res.placed          = 1'b1;
                            res.placed_position = POS_W'(i);
                        end
                    end
                end
                ACT_READ:
                begin
                    // Positions beyond the length and empty slots read as zero.
                    if (beat.read_index < len && marks[beat.read_index])
                    begin
                        res.entry_valid = 1'b1;
                        res.entry_count = counts[beat.read_index];
                        res.entry_tag   = tags[beat.read_index];
                    end
                end
                default:
                begin
                end
            endcase
            due_results.push_back(res);
        endfunction

        // Compare a result beat with the oldest one still due.
        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                want = due_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result mismatch (expected/actual): placed %b/%b pos %0d/%0d",
                                  " valid %b/%b count %h/%h tag %h/%h"},
                                 want.placed, got.placed,
                                 want.placed_position, got.placed_position,
                                 want.entry_valid, got.entry_valid,
                                 want.entry_count, got.entry_count,
                                 want.entry_tag, got.entry_tag);
                end
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    in_beat_t            in_data;
    logic                out_valid;
    logic                out_stall;
    out_beat_t           out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ranking_board board;
    bit           hold_request = 1'b0;
    int           cycle_count  = 0;

    top_n_insertion_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // Check result beats before noting the input beat of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_beat(out_data);
            if (in_valid && !in_stall)
                board.note_beat(in_data);
        end
    end

    // Stall the result side in regimes of random length; hold off fully on request.
    initial
    begin : stall_pattern
        int hold_left;
        int regime_left;
        int stall_pct;
        hold_left   = 0;
        regime_left = 0;
        stall_pct   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (regime_left == 0)
            begin
                regime_left = $urandom_range(10, 80);
                case ($urandom_range(3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            regime_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // End the run if it overstays its limit.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("top_n_insertion_list regression: fail");
        $finish;
    end

    function automatic in_beat_t beat_of(action_t act, logic [COUNT_W-1:0] count,
                                         logic [TAG_W-1:0] tag, logic [POS_W-1:0] index);
        in_beat_t beat;
        beat.action      = act;
        beat.offer_count = count;
        beat.offer_tag   = tag;
        beat.read_index  = index;
        return beat;
    endfunction

    // Mostly offers, with small counts for ties and near-full counts at the top.
    function automatic in_beat_t make_beat();
        in_beat_t beat;
        int       pick;
        beat.offer_count = $urandom;
        beat.offer_tag   = $urandom;
        beat.read_index  = POS_W'($urandom_range(15));
        pick             = $urandom_range(99);
        if (pick < 55)
        begin
            beat.action = ACT_OFFER;
            case ($urandom_range(3))
                0:       beat.offer_count = $urandom_range(40);
                1:       beat.offer_count = $urandom_range(3);
                2:       beat.offer_count = 32'hFFFF_FFFF - $urandom_range(7);
                default: beat.offer_count = $urandom;
            endcase
        end
        else if (pick < 90)
            beat.action = ACT_READ;
        else if (pick < 95)
            beat.action = ACT_CLEAR;
        else
            beat.action = ACT_NONE;
        return beat;
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_beat(input in_beat_t beat);
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send random beats in bursts, with random gaps between some bursts unless gapless is set.
    task automatic send_items(input int total, input bit gapless);
        int sent;
        int burst;
        sent = 0;
        while (sent < total)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < total)
            begin
                send_beat(make_beat());
                sent++;
                burst--;
            end
            if (!gapless && sent < total && $urandom_range(3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Wait until every due result has arrived, then let the pipeline settle.
    task automatic wait_idle();
        @(posedge clk);
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write list_length with junk in the unused upper bits.
    task automatic write_length(input logic [LENREG_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word = ($urandom & ~PDATA_W'(5'h1F)) | PDATA_W'(value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_LIST_LENGTH, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_length(word);
    endtask

    initial
    begin : stimulus
        logic [LENREG_W-1:0] lengths [PHASES];
        board     = new();
        lengths   = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd5, 5'd1, 5'd1, 5'd10};
        lengths[5] = LENREG_W'($urandom_range(1, 16));
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, ties, a full list, no place found, clear; reset length of ten.
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd0,          32'hFFFF_FFFF,  4'd0));
        send_beat(beat_of(ACT_OFFER, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  4'd15));
        send_beat(beat_of(ACT_OFFER, 32'd5,          32'd0,          4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd5,          32'd1,          4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd100,        32'hA5A5_A5A5,  4'd0));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd0));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd2));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd9));
        send_beat(beat_of(ACT_READ,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  4'd15));
        send_beat(beat_of(ACT_NONE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  4'd15));
        for (int k = 0; k < 6; k++)
            send_beat(beat_of(ACT_OFFER, 32'd1000 - k, 32'h100 + k, 4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd1,          32'h5A5A_5A5A,  4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd2000,       32'h0F0F_0F0F,  4'd0));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd9));
        send_beat(beat_of(ACT_CLEAR, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  4'd15));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd0));
        in_valid <= 1'b0;
        wait_idle();

        // Single position: ties and smaller counts find no place.
        write_length(5'd1);
        send_beat(beat_of(ACT_OFFER, 32'd7,          32'd70,         4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd3,          32'd30,         4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd7,          32'd71,         4'd0));
        send_beat(beat_of(ACT_OFFER, 32'd9,          32'd90,         4'd0));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd0));
        send_beat(beat_of(ACT_READ,  32'd0,          32'd0,          4'd1));
        in_valid <= 1'b0;

        // Random phases across lengths; the first one fills the block under a long hold.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_length(lengths[p]);
            if (p == 0)
            begin
                hold_request = 1'b1;
                send_items(40, 1'b1);
            end
            send_items(60, 1'b0);
        end
        wait_idle();

        if (board.mismatch_count == 0 && board.due_results.size() == 0)
            $display("top_n_insertion_list regression: pass");
        else
            $display("top_n_insertion_list regression: fail");
        $finish;
    end

endmodule

[top_n_insertion_list.f]
sv/tnil_pkg.sv
sv/tnil_cell.sv
sv/top_n_insertion_list.sv
verif/top_n_insertion_list_tb.sv
